// ===== src/ptg_pkg.sv =====
// Shared types and constants for the TSC field gather block.
// No dependencies; used by ptg_lane and pic_tsc_field_gather_2d.
`timescale 1ns / 1ps

package ptg_pkg;

	localparam int ADDR_W   = 12;
	localparam int DEPTH    = 4096;
	localparam int VAL_W    = 32;
	localparam int FRAC_W   = 16;
	localparam int WGT_W    = 16;
	localparam int ACC_W    = 56;
	localparam int IDX_W    = 35;
	localparam int DLT_W    = 17;

	// Register indexes on the configuration channel
	localparam logic [2:0] REG_COLS   = 3'd0;
	localparam logic [2:0] REG_ROWS   = 3'd1;
	localparam logic [2:0] REG_ORG_X  = 3'd2;
	localparam logic [2:0] REG_ORG_Y  = 3'd3;
	localparam logic [2:0] REG_INV_X  = 3'd4;
	localparam logic [2:0] REG_INV_Y  = 3'd5;

	// Item kinds on the input tuser
	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_PARTICLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_MUL,
		ST_IDX,
		ST_WGT,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Per-point control handed to each lane
	typedef struct packed {
		logic clr;
		logic vld;
		logic ok;
	} lane_ctl_t;

endpackage

// ===== src/pic_tsc_field_gather_2d.sv =====
// Top level of the quadratic-weight field gather on a staggered 2D grid.
// Depends on ptg_pkg and ptg_lane.
`timescale 1ns / 1ps

// The block holds six 4096-word field memories (Ex, Ey, Ez, Bx, By, Bz) and
// answers one particle at a time. A load item (tuser bit 0 low) writes one
// cell of all six memories at once and gives no result. A particle item
// steps through subtract, two split multiplies, index and weight setup, a
// walk of the 3x3 stencil with one read per memory per cycle, and a drain of
// the read, multiply and accumulate pipeline before its result. A dead
// particle goes straight to the result. Each result sits in an output
// register; the next item is taken while it waits. Cells must be loaded
// before a particle reads them.
module pic_tsc_field_gather_2d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_address, ex_in, ey_in, ez_in, bx_in, by_in, bz_in, pos_x, pos_y, 4 pad
	input  logic [271:0] s_tdata,
	// mode, dead_flag
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ex_out, ey_out, ez_out, bx_out, by_out, bz_out
	output logic [191:0] m_tdata,
	// skipped, out_of_range
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int HALF    = 1 << (ptg_pkg::FRAC_W - 1);
	localparam int QUARTER = 1 << (ptg_pkg::FRAC_W - 2);

	ptg_pkg::state_t state_q, state_d;

	logic [6:0]         cols_q, rows_q;
	logic signed [31:0] org_x_q, org_y_q;
	logic [31:0]        inv_x_q, inv_y_q;

	logic signed [31:0] pos_x_q, pos_y_q;
	logic               last_q, skip_q, oor_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [49:0] px_hi_q, px_lo_q, py_hi_q, py_lo_q;

	logic signed [ptg_pkg::IDX_W-1:0] ixc_q, ixh_q, iyc_q, iyh_q;
	logic signed [ptg_pkg::DLT_W-1:0] dxc_q, dxh_q, dyc_q, dyh_q;
	logic [ptg_pkg::WGT_W-1:0] wxc_q [3], wxh_q [3], wyc_q [3], wyh_q [3];

	logic [1:0] a_q, b_q, drain_q;

	logic in_xfer, load_xfer, part_xfer, out_free;
	logic clr_acc, run_en, load_out;

	logic signed [31:0] ex_v, ey_v, ez_v, bx_v, by_v, bz_v, r_ex, r_ey, r_ez, r_bx, r_by, r_bz;

	logic [ptg_pkg::ADDR_W:0] pt_cc, pt_ch, pt_hc, pt_hh;
	logic [ptg_pkg::ADDR_W-1:0] addr_cc_s1, addr_ch_s1, addr_hc_s1, addr_hh_s1;
	logic [ptg_pkg::WGT_W-1:0]  w_cc_s1, w_ch_s1, w_hc_s1, w_hh_s1;
	logic ok_cc_s1, ok_ch_s1, ok_hc_s1, ok_hh_s1, vld_s1;
	ptg_pkg::lane_ctl_t ctl_cc, ctl_ch, ctl_hc, ctl_hh;

	// Wrap one stencil coordinate pair and form its linear address
	function automatic logic [ptg_pkg::ADDR_W:0] cell_addr(
		input logic signed [ptg_pkg::IDX_W-1:0] ib,
		input logic [1:0]                       ia,
		input logic signed [ptg_pkg::IDX_W-1:0] jb,
		input logic [1:0]                       jb_off,
		input logic [6:0]                       nx,
		input logic [6:0]                       ny
	);
		logic signed [ptg_pkg::IDX_W:0] i, j;
		logic [13:0] lim;
		logic [19:0] lin;
		logic        bad;
		i = (ptg_pkg::IDX_W+1)'(ib) + $signed({{(ptg_pkg::IDX_W-1){1'b0}}, ia}) - 1;
		j = (ptg_pkg::IDX_W+1)'(jb) + $signed({{(ptg_pkg::IDX_W-1){1'b0}}, jb_off}) - 1;
		if (i < 0) begin
			i = i + $signed({{(ptg_pkg::IDX_W-6){1'b0}}, nx});
		end
		if (j < 0) begin
			j = j + $signed({{(ptg_pkg::IDX_W-6){1'b0}}, ny});
		end
		lim = 14'(nx * ny);
		if (lim > 14'(ptg_pkg::DEPTH)) begin
			lim = 14'(ptg_pkg::DEPTH);
		end
		bad = (i < 0) || (j < 0) || (i >= ptg_pkg::DEPTH) || (j >= ptg_pkg::DEPTH);
		lin = 20'(j[ptg_pkg::ADDR_W-1:0]) + 20'(i[ptg_pkg::ADDR_W-1:0] * ny);
		if (lin >= 20'(lim)) begin
			bad = 1'b1;
		end
		return {~bad, lin[ptg_pkg::ADDR_W-1:0]};
	endfunction

	// Stencil weight of one point
	function automatic logic [ptg_pkg::WGT_W-1:0] pt_wgt(
		input logic [ptg_pkg::WGT_W-1:0] wy,
		input logic [ptg_pkg::WGT_W-1:0] wx
	);
		logic [2*ptg_pkg::WGT_W-1:0] p;
		p = wy * wx;
		return p[ptg_pkg::FRAC_W +: ptg_pkg::WGT_W];
	endfunction

	assign in_xfer   = s_tvalid && s_tready;
	assign load_xfer = in_xfer && (s_tuser[0] == ptg_pkg::MODE_LOAD);
	assign part_xfer = in_xfer && (s_tuser[0] == ptg_pkg::MODE_PARTICLE);
	assign out_free  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptg_pkg::ST_IDLE: begin
				if (part_xfer) begin
					state_d = s_tuser[1] ? ptg_pkg::ST_DONE : ptg_pkg::ST_SUB;
				end
			end
			ptg_pkg::ST_SUB: state_d = ptg_pkg::ST_MUL;
			ptg_pkg::ST_MUL: state_d = ptg_pkg::ST_IDX;
			ptg_pkg::ST_IDX: state_d = ptg_pkg::ST_WGT;
			ptg_pkg::ST_WGT: state_d = ptg_pkg::ST_RUN;
			ptg_pkg::ST_RUN: begin
				if (a_q == 2'd2 && b_q == 2'd2) begin
					state_d = ptg_pkg::ST_DRAIN;
				end
			end
			ptg_pkg::ST_DRAIN: begin
				if (drain_q == 2'd2) begin
					state_d = ptg_pkg::ST_DONE;
				end
			end
			ptg_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ptg_pkg::ST_IDLE;
				end
			end
			default: state_d = ptg_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready = 1'b0;
		clr_acc  = 1'b0;
		run_en   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ptg_pkg::ST_IDLE: s_tready = 1'b1;
			ptg_pkg::ST_WGT:  clr_acc  = 1'b1;
			ptg_pkg::ST_RUN:  run_en   = 1'b1;
			ptg_pkg::ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= 7'd64;
			rows_q  <= 7'd64;
			org_x_q <= '0;
			org_y_q <= '0;
			inv_x_q <= 32'd65536;
			inv_y_q <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptg_pkg::REG_COLS:  cols_q  <= cfg_data[6:0];
				ptg_pkg::REG_ROWS:  rows_q  <= cfg_data[6:0];
				ptg_pkg::REG_ORG_X: org_x_q <= cfg_data;
				ptg_pkg::REG_ORG_Y: org_y_q <= cfg_data;
				ptg_pkg::REG_INV_X: inv_x_q <= cfg_data;
				ptg_pkg::REG_INV_Y: inv_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the particle
	always_ff @(posedge clk) begin
		if (part_xfer) begin
			pos_x_q <= s_tdata[235:204];
			pos_y_q <= s_tdata[267:236];
			last_q  <= s_tlast;
			skip_q  <= s_tuser[1];
		end
	end

	// Scale to cell units: offset, then split multiply (combined in the index step)
	always_ff @(posedge clk) begin
		dx_q    <= 33'(pos_x_q) - 33'(org_x_q);
		dy_q    <= 33'(pos_y_q) - 33'(org_y_q);
		px_hi_q <= dx_q * $signed({1'b0, inv_x_q[31:16]});
		px_lo_q <= dx_q * $signed({1'b0, inv_x_q[15:0]});
		py_hi_q <= dy_q * $signed({1'b0, inv_y_q[31:16]});
		py_lo_q <= dy_q * $signed({1'b0, inv_y_q[15:0]});
	end

	// Centred and half-shifted indices with their deltas
	always_ff @(posedge clk) begin : idx_blk
		logic signed [50:0] sx, sy, tx, ty;
		if (state_q == ptg_pkg::ST_IDX) begin
			sx = 51'(px_hi_q) + 51'(px_lo_q >>> ptg_pkg::FRAC_W);
			sy = 51'(py_hi_q) + 51'(py_lo_q >>> ptg_pkg::FRAC_W);
			tx = sx + 51'(HALF);
			ty = sy + 51'(HALF);
			ixc_q <= tx[50:ptg_pkg::FRAC_W];
			ixh_q <= sx[50:ptg_pkg::FRAC_W];
			iyc_q <= ty[50:ptg_pkg::FRAC_W];
			iyh_q <= sy[50:ptg_pkg::FRAC_W];
			dxc_q <= 17'(HALF) - $signed({1'b0, tx[ptg_pkg::FRAC_W-1:0]});
			dxh_q <= 17'(HALF) - $signed({1'b0, sx[ptg_pkg::FRAC_W-1:0]});
			dyc_q <= 17'(HALF) - $signed({1'b0, ty[ptg_pkg::FRAC_W-1:0]});
			dyh_q <= 17'(HALF) - $signed({1'b0, sy[ptg_pkg::FRAC_W-1:0]});
		end
	end

	// Quadratic weights for one delta
	function automatic logic [3*ptg_pkg::WGT_W-1:0] tsc_wgt(
		input logic signed [ptg_pkg::DLT_W-1:0] dl
	);
		logic signed [33:0] sq;
		logic signed [19:0] d2, w0, w1, w2;
		sq = dl * dl;
		d2 = 20'(sq >>> ptg_pkg::FRAC_W);
		w0 = (20'(QUARTER) + d2 + 20'(dl)) >>> 1;
		w1 = 20'(3 * QUARTER) - d2;
		w2 = (20'(QUARTER) + d2 - 20'(dl)) >>> 1;
		return {w2[ptg_pkg::WGT_W-1:0], w1[ptg_pkg::WGT_W-1:0], w0[ptg_pkg::WGT_W-1:0]};
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ptg_pkg::ST_WGT) begin
			{wxc_q[2], wxc_q[1], wxc_q[0]} <= tsc_wgt(dxc_q);
			{wxh_q[2], wxh_q[1], wxh_q[0]} <= tsc_wgt(dxh_q);
			{wyc_q[2], wyc_q[1], wyc_q[0]} <= tsc_wgt(dyc_q);
			{wyh_q[2], wyh_q[1], wyh_q[0]} <= tsc_wgt(dyh_q);
		end
	end

	// Stencil walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			drain_q <= '0;
		end else if (state_q == ptg_pkg::ST_WGT) begin
			a_q     <= '0;
			b_q     <= '0;
			drain_q <= '0;
		end else if (run_en) begin
			if (a_q == 2'd2) begin
				a_q <= '0;
				b_q <= b_q + 2'd1;
			end else begin
				a_q <= a_q + 2'd1;
			end
		end else if (state_q == ptg_pkg::ST_DRAIN) begin
			drain_q <= drain_q + 2'd1;
		end
	end

	// Addresses for the four index pairings: x first, y second
	assign pt_cc = cell_addr(ixc_q, a_q, iyc_q, b_q, cols_q, rows_q);
	assign pt_ch = cell_addr(ixc_q, a_q, iyh_q, b_q, cols_q, rows_q);
	assign pt_hc = cell_addr(ixh_q, a_q, iyc_q, b_q, cols_q, rows_q);
	assign pt_hh = cell_addr(ixh_q, a_q, iyh_q, b_q, cols_q, rows_q);

	always_ff @(posedge clk) begin
		addr_cc_s1 <= pt_cc[ptg_pkg::ADDR_W-1:0];
		addr_ch_s1 <= pt_ch[ptg_pkg::ADDR_W-1:0];
		addr_hc_s1 <= pt_hc[ptg_pkg::ADDR_W-1:0];
		addr_hh_s1 <= pt_hh[ptg_pkg::ADDR_W-1:0];
		ok_cc_s1   <= pt_cc[ptg_pkg::ADDR_W];
		ok_ch_s1   <= pt_ch[ptg_pkg::ADDR_W];
		ok_hc_s1   <= pt_hc[ptg_pkg::ADDR_W];
		ok_hh_s1   <= pt_hh[ptg_pkg::ADDR_W];
		w_cc_s1    <= pt_wgt(wyc_q[b_q], wxc_q[a_q]);
		w_ch_s1    <= pt_wgt(wyh_q[b_q], wxc_q[a_q]);
		w_hc_s1    <= pt_wgt(wyc_q[b_q], wxh_q[a_q]);
		w_hh_s1    <= pt_wgt(wyh_q[b_q], wxh_q[a_q]);
	end

	// Point valid and out-of-range flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			oor_q  <= 1'b0;
		end else begin
			vld_s1 <= run_en;
			if (clr_acc) begin
				oor_q <= 1'b0;
			end else if (run_en && !(pt_cc[ptg_pkg::ADDR_W] && pt_ch[ptg_pkg::ADDR_W]
					&& pt_hc[ptg_pkg::ADDR_W] && pt_hh[ptg_pkg::ADDR_W])) begin
				oor_q <= 1'b1;
			end
		end
	end

	assign ctl_cc = '{clr: clr_acc, vld: vld_s1, ok: ok_cc_s1};
	assign ctl_ch = '{clr: clr_acc, vld: vld_s1, ok: ok_ch_s1};
	assign ctl_hc = '{clr: clr_acc, vld: vld_s1, ok: ok_hc_s1};
	assign ctl_hh = '{clr: clr_acc, vld: vld_s1, ok: ok_hh_s1};

	ptg_lane u_ex (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[43:12]), .rd_addr(addr_hc_s1), .ctl(ctl_hc), .weight(w_hc_s1),
		.result(r_ex));
	ptg_lane u_ey (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[75:44]), .rd_addr(addr_ch_s1), .ctl(ctl_ch), .weight(w_ch_s1),
		.result(r_ey));
	ptg_lane u_ez (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[107:76]), .rd_addr(addr_cc_s1), .ctl(ctl_cc), .weight(w_cc_s1),
		.result(r_ez));
	ptg_lane u_bx (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[139:108]), .rd_addr(addr_ch_s1), .ctl(ctl_ch), .weight(w_ch_s1),
		.result(r_bx));
	ptg_lane u_by (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[171:140]), .rd_addr(addr_hc_s1), .ctl(ctl_hc), .weight(w_hc_s1),
		.result(r_by));
	ptg_lane u_bz (.clk, .arst_n, .wr_en(load_xfer), .wr_addr(s_tdata[11:0]),
		.wr_data(s_tdata[203:172]), .rd_addr(addr_hh_s1), .ctl(ctl_hh), .weight(w_hh_s1),
		.result(r_bz));

	// Dead particles report zero fields
	assign ex_v = skip_q ? '0 : r_ex;
	assign ey_v = skip_q ? '0 : r_ey;
	assign ez_v = skip_q ? '0 : r_ez;
	assign bx_v = skip_q ? '0 : r_bx;
	assign by_v = skip_q ? '0 : r_by;
	assign bz_v = skip_q ? '0 : r_bz;

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {bz_v, by_v, bx_v, ez_v, ey_v, ex_v};
			m_tuser <= {oor_q && !skip_q, skip_q};
			m_tlast <= last_q;
		end
	end

endmodule

// ===== src/ptg_lane.sv =====
// One field lane: cell memory, weighted multiply and stencil accumulator.
// Depends on ptg_pkg.
`timescale 1ns / 1ps

module ptg_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ptg_pkg::ADDR_W-1:0]          wr_addr,
	input  logic signed [ptg_pkg::VAL_W-1:0]    wr_data,
	input  logic [ptg_pkg::ADDR_W-1:0]          rd_addr,
	input  ptg_pkg::lane_ctl_t                  ctl,
	input  logic [ptg_pkg::WGT_W-1:0]           weight,
	output logic signed [ptg_pkg::VAL_W-1:0]    result
);

	logic signed [ptg_pkg::VAL_W-1:0] mem [ptg_pkg::DEPTH];
	logic signed [ptg_pkg::VAL_W-1:0] rdata_s2;
	logic                             vld_s2, ok_s2, vld_s3;
	logic [ptg_pkg::WGT_W-1:0]        w_s2;
	logic signed [ptg_pkg::VAL_W+ptg_pkg::WGT_W:0] prod_s3;
	logic signed [ptg_pkg::ACC_W-1:0] acc_q;
	logic signed [ptg_pkg::ACC_W-ptg_pkg::FRAC_W-1:0] sum;

	// Write on load, read one stencil point per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s2 <= mem[rd_addr];
		w_s2     <= weight;
	end

	// Track point validity down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			ok_s2  <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
			ok_s2  <= ctl.ok;
			vld_s3 <= vld_s2;
		end
	end

	// Weight the sample; points outside the grid add zero
	always_ff @(posedge clk) begin
		if (ok_s2) begin
			prod_s3 <= rdata_s2 * $signed({1'b0, w_s2});
		end else begin
			prod_s3 <= '0;
		end
	end

	// Accumulate the stencil
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s3) begin
			acc_q <= acc_q + ptg_pkg::ACC_W'(prod_s3);
		end
	end

	// Drop fraction bits and saturate
	assign sum = acc_q[ptg_pkg::ACC_W-1:ptg_pkg::FRAC_W];

	always_comb begin
		if (sum > $signed({{(ptg_pkg::ACC_W-ptg_pkg::FRAC_W-ptg_pkg::VAL_W+1){1'b0}},
				{(ptg_pkg::VAL_W-1){1'b1}}})) begin
			result = {1'b0, {(ptg_pkg::VAL_W-1){1'b1}}};
		end else if (sum < $signed({{(ptg_pkg::ACC_W-ptg_pkg::FRAC_W-ptg_pkg::VAL_W+1){1'b1}},
				{(ptg_pkg::VAL_W-1){1'b0}}})) begin
			result = {1'b1, {(ptg_pkg::VAL_W-1){1'b0}}};
		end else begin
			result = sum[ptg_pkg::VAL_W-1:0];
		end
	end

endmodule

// ===== tb/tb_pic_tsc_field_gather_2d.sv =====
// Self-checking testbench for pic_tsc_field_gather_2d: loads field cells,
// sends particles, and checks every result against an in-bench predictor.
// Depends on ptg_pkg and the pic_tsc_field_gather_2d RTL.
`timescale 1ns / 1ps

module tb_pic_tsc_field_gather_2d;

	localparam int        CLK_HALF    = 4;
	localparam int        STALL_LIMIT = 20000;
	localparam int        DRAIN_WAIT  = 40;
	localparam int        QUIET_START = 1500;
	localparam int        QUIET_END   = 3000;
	localparam int        HOLD_START  = 6000;
	localparam int        HOLD_END    = 6800;
	localparam int        PHASE_ITEMS = 250;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam longint    ONE_Q       = 65536;

	typedef struct {
		logic        mode;
		logic [11:0] addr;
		logic [31:0] fval[6];
		logic [31:0] px;
		logic [31:0] py;
		logic        dead;
		logic        last;
	} grid_item_t;

	typedef struct packed {
		logic [191:0] fields;
		logic         oor;
		logic         skipped;
		logic         last;
	} gather_res_t;

	typedef struct {
		grid_item_t  item;
		bit          has_exp;
		gather_res_t exp;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [271:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	// Predictor state: field memories and register copies
	logic [31:0]  field_mem[6][ptg_pkg::DEPTH];
	logic [6:0]   cols_q;
	logic [6:0]   rows_q;
	logic [31:0]  org_x_q;
	logic [31:0]  org_y_q;
	logic [31:0]  inv_x_q;
	logic [31:0]  inv_y_q;

	gather_res_t  pending_q[$];
	int           failures;

	pic_tsc_field_gather_2d i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Position in cell units, FRAC_W fraction bits
	function automatic longint scale_to_cells(logic [31:0] pos, logic [31:0] org,
			logic [31:0] inv);
		longint d;
		longint hi;
		longint lo;
		d  = longint'($signed(pos)) - longint'($signed(org));
		hi = longint'(inv >> ptg_pkg::FRAC_W);
		lo = longint'(inv & 32'h0000_FFFF);
		return d * hi + ((d * lo) >>> ptg_pkg::FRAC_W);
	endfunction

	// Floor index and the three quadratic weights
	function automatic longint tsc_index(longint t, output longint w[3]);
		longint fr;
		longint delta;
		longint d2;
		fr    = t & 64'hFFFF;
		delta = 32768 - fr;
		d2    = (delta * delta) >>> ptg_pkg::FRAC_W;
		w[0]  = (16384 + d2 + delta) >>> 1;
		w[1]  = 49152 - d2;
		w[2]  = (16384 + d2 - delta) >>> 1;
		return t >>> ptg_pkg::FRAC_W;
	endfunction

	// Weighted 3x3 sum over one field memory, floored and saturated
	function automatic logic [31:0] stencil_sum(int fld, longint ix, longint wx[3],
			longint iy, longint wy[3], inout bit oor);
		longint nx;
		longint ny;
		longint lim;
		longint acc;
		longint i;
		longint j;
		longint a_ix;
		longint r;
		nx  = longint'(cols_q);
		ny  = longint'(rows_q);
		lim = nx * ny;
		acc = 0;
		if (lim > ptg_pkg::DEPTH)
			lim = ptg_pkg::DEPTH;
		for (int b = 0; b < 3; b++) begin
			for (int a = 0; a < 3; a++) begin
				i = ix + a - 1;
				j = iy + b - 1;
				if (i < 0)
					i += nx;
				if (j < 0)
					j += ny;
				a_ix = j + i * ny;
				if (i < 0 || j < 0 || a_ix < 0 || a_ix >= lim) begin
					oor = 1'b1;
				end else begin
					acc += longint'($signed(field_mem[fld][a_ix]))
						* ((wy[b] * wx[a]) >>> ptg_pkg::FRAC_W);
				end
			end
		end
		r = acc >>> ptg_pkg::FRAC_W;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Apply one accepted item to the predictor; queue the result it causes
	task automatic predict_gather(grid_item_t it);
		gather_res_t res;
		longint      sx;
		longint      sy;
		longint      ix_c;
		longint      ix_h;
		longint      iy_c;
		longint      iy_h;
		longint      gx[3];
		longint      hx[3];
		longint      gy[3];
		longint      hy[3];
		bit          oor;
		if (it.mode == ptg_pkg::MODE_LOAD) begin
			for (int k = 0; k < 6; k++)
				field_mem[k][it.addr] = it.fval[k];
			return;
		end
		res      = '0;
		res.last = it.last;
		oor      = 1'b0;
		if (it.dead) begin
			res.skipped = 1'b1;
		end else begin
			sx   = scale_to_cells(it.px, org_x_q, inv_x_q);
			sy   = scale_to_cells(it.py, org_y_q, inv_y_q);
			ix_c = tsc_index(sx + 32768, gx);
			ix_h = tsc_index(sx, hx);
			iy_c = tsc_index(sy + 32768, gy);
			iy_h = tsc_index(sy, hy);
			res.fields[0   +: 32] = stencil_sum(0, ix_h, hx, iy_c, gy, oor);
			res.fields[32  +: 32] = stencil_sum(1, ix_c, gx, iy_h, hy, oor);
			res.fields[64  +: 32] = stencil_sum(2, ix_c, gx, iy_c, gy, oor);
			res.fields[96  +: 32] = stencil_sum(3, ix_c, gx, iy_h, hy, oor);
			res.fields[128 +: 32] = stencil_sum(4, ix_h, hx, iy_c, gy, oor);
			res.fields[160 +: 32] = stencil_sum(5, ix_h, hx, iy_h, hy, oor);
			res.oor = oor;
		end
		pending_q.push_back(res);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		failures++;
	endtask

	// Hold one item on the input until its transfer, with optional random gaps ahead
	task automatic send_item(grid_item_t it, bit gaps);
		if (gaps) begin
			while ($urandom_range(0, 99) < 23) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tdata  = {4'b0, it.py, it.px, it.fval[5], it.fval[4], it.fval[3],
			it.fval[2], it.fval[1], it.fval[0], it.addr};
		s_tuser  = {it.dead, it.mode};
		s_tlast  = it.last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_gather(it);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			ptg_pkg::REG_COLS:  cols_q  = val[6:0];
			ptg_pkg::REG_ROWS:  rows_q  = val[6:0];
			ptg_pkg::REG_ORG_X: org_x_q = val;
			ptg_pkg::REG_ORG_Y: org_y_q = val;
			ptg_pkg::REG_INV_X: inv_x_q = val;
			ptg_pkg::REG_INV_Y: inv_y_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait out every pending result, then let the block settle
	task automatic wait_idle();
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic grid_item_t rand_load();
		grid_item_t it;
		it      = '{default: '0, fval: '{default: '0}};
		it.mode = ptg_pkg::MODE_LOAD;
		it.addr = 12'($urandom);
		for (int k = 0; k < 6; k++)
			it.fval[k] = $urandom;
		it.px   = $urandom;
		it.py   = $urandom;
		it.dead = 1'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	// Position that lands near the grid in cell units under the current setting
	function automatic logic [31:0] near_grid(longint n, logic [31:0] org, logic [31:0] inv);
		longint target;
		longint d;
		target = longint'($urandom_range(0, 32'((n + 4) * ONE_Q))) - 2 * ONE_Q;
		d      = (target * ONE_Q) / longint'(inv);
		return 32'(longint'($signed(org)) + d);
	endfunction

	function automatic grid_item_t rand_particle();
		grid_item_t it;
		it      = rand_load();
		it.mode = ptg_pkg::MODE_PARTICLE;
		it.dead = ($urandom_range(0, 99) < 8);
		if ($urandom_range(0, 99) >= 20) begin
			it.px = near_grid(longint'(cols_q), org_x_q, inv_x_q);
			it.py = near_grid(longint'(rows_q), org_y_q, inv_y_q);
		end
		return it;
	endfunction

	// Receiver: random stalls, one quiet stretch, one long hold-off
	initial begin
		int          rx_cycle;
		gather_res_t want;
		m_tready = 1'b0;
		rx_cycle = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result", 32'd1, 32'd0);
				end else begin
					want = pending_q.pop_front();
					for (int k = 0; k < 6; k++) begin
						if (m_tdata[32*k +: 32] !== want.fields[32*k +: 32])
							report_mismatch($sformatf("field %0d", k),
								m_tdata[32*k +: 32], want.fields[32*k +: 32]);
					end
					if (m_tuser[0] !== want.skipped)
						report_mismatch("skipped", m_tuser[0], want.skipped);
					if (m_tuser[1] !== want.oor)
						report_mismatch("out_of_range", m_tuser[1], want.oor);
					if (m_tlast !== want.last)
						report_mismatch("last", m_tlast, want.last);
				end
			end
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_END)
				m_tready = 1'b0;
			else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END)
				m_tready = 1'b1;
			else
				m_tready = ($urandom_range(0, 99) >= 23);
		end
	end

	// Watchdog: end the run after too many cycles with no transfer
	initial begin
		int still;
		still = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				still = 0;
			else
				still++;
			if (still >= STALL_LIMIT) begin
				$display("pic_tsc_field_gather_2d test failed");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t    rows[$];
		dir_row_t    row;
		grid_item_t  it;
		logic [31:0] phase_cfg[6][6];
		failures  = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ptg_pkg::REG_COLS;
		cfg_data  = '0;
		cols_q    = 7'd64;
		rows_q    = 7'd64;
		org_x_q   = '0;
		org_y_q   = '0;
		inv_x_q   = 32'h0001_0000;
		inv_y_q   = 32'h0001_0000;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every cell so no read ever hits an unwritten one
		for (int a = 0; a < ptg_pkg::DEPTH; a++) begin
			it      = rand_load();
			it.addr = 12'(a);
			send_item(it, 1'b0);
		end

		// Directed rows under reset settings
		it      = rand_load();
		it.addr = 12'd0;
		it.fval = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		rows.push_back('{it, 1'b0, '0});
		it.addr = 12'd4095;
		rows.push_back('{it, 1'b0, '0});
		it.addr = 12'd65;
		it.fval = '{default: 32'h7FFF_FFFF};
		rows.push_back('{it, 1'b0, '0});
		it      = rand_particle();
		it.dead = 1'b1;
		it.last = 1'b1;
		rows.push_back('{it, 1'b1, '{fields: '0, oor: 1'b0, skipped: 1'b1, last: 1'b1}});
		it.last = 1'b0;
		it.px   = 32'h8000_0000;
		rows.push_back('{it, 1'b1, '{fields: '0, oor: 1'b0, skipped: 1'b1, last: 1'b0}});
		it.dead = 1'b0;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h7FFF_FFFF; it.py = 32'h7FFF_FFFF;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h8000_0000; it.py = 32'h8000_0000;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h0; it.py = 32'h0;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h0001_8000; it.py = 32'h0001_0000;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h003F_C000; it.py = 32'h003F_FFFF; it.last = 1'b1;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'h0020_8000; it.py = 32'h0010_4000; it.last = 1'b0;
		rows.push_back('{it, 1'b0, '0});
		it.px = 32'hFFFF_8000; it.py = 32'h0040_0000;
		rows.push_back('{it, 1'b0, '0});
		foreach (rows[r]) begin
			row = rows[r];
			if (row.has_exp) begin
				send_item(row.item, 1'b1);
				void'(pending_q.pop_back());
				pending_q.push_back(row.exp);
			end else begin
				send_item(row.item, 1'b1);
			end
		end

		// Register settings walked in turn: cols, rows, org x/y, inv x/y
		phase_cfg[0] = '{32'd64, 32'd64, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000};
		phase_cfg[1] = '{32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF};
		phase_cfg[2] = '{32'd127, 32'd127, $urandom, $urandom, 32'h0002_0000, 32'h0000_8000};
		phase_cfg[3] = '{32'd0, 32'd5, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000};
		phase_cfg[4] = '{32'd7, 32'd64, $urandom, $urandom,
			$urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000)};
		phase_cfg[5] = '{32'd64, 32'd3, 32'hFFF0_0000, 32'h0010_0000,
			32'hFFFF_FFFF, 32'h0000_0001};
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			for (int k = 0; k < 6; k++)
				write_reg(3'(k), phase_cfg[p][k]);
			if (p == 2) begin
				write_reg(REG_SPARE_A, $urandom);
				write_reg(REG_SPARE_B, $urandom);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 25)
					send_item(rand_load(), 1'b1);
				else
					send_item(rand_particle(), 1'b1);
			end
		end

		wait_idle();
		if (failures == 0)
			$display("pic_tsc_field_gather_2d test passed");
		else
			$display("pic_tsc_field_gather_2d test failed");
		$finish;
	end

endmodule
